FILE: src/asac_pkg.sv
// Shared types and constants for the accelerometer step and activity classifier.
package asac_pkg;

    localparam int AXIS_W   = 16;
    localparam int IN_W     = 3 * AXIS_W;
    localparam int MAG_W    = 18;
    localparam int LOCK_W   = 8;
    localparam int CLASS_W  = 2;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [MAG_W-1:0] ONE_G_MG = MAG_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT   = 3'd4;

    localparam logic [CLASS_W-1:0] CLASS_INACTIVE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SLOW     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NORMAL   = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_FAST     = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0]  step_threshold_mg;
        logic [LOCK_W-1:0] lockout_samples;
        logic [MAG_W-1:0]  inactive_limit_mg;
        logic [MAG_W-1:0]  slow_limit_mg;
        logic [MAG_W-1:0]  normal_limit_mg;
    } cfg_t;

    typedef struct packed {
        logic [CLASS_W-1:0] activity_class;
        logic               step_detected;
        logic [MAG_W-1:0]   magnitude_mg;
    } res_t;

endpackage

FILE: src/accel_step_and_activity_classifier.sv
// Top level: configuration registers, front end, queue and back end of the step classifier.
// Throughput is set by the square root unit, which retires one result bit per cycle and
// takes no new sample until its result is loaded; the front end and queue absorb bursts.
// Reset (aresetn, synchronous, active low) empties all stages, clears the stored
// magnitude and lockout count, and loads thresholds 200/5/30/150/300.
module accel_step_and_activity_classifier #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [asac_pkg::IN_W-1:0]         s_tdata,   // accel_x, accel_y, accel_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [asac_pkg::OUT_W-1:0]        m_tdata,   // magnitude_mg, step_detected, activity_class
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [asac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int SUM_W = 2 * SAMPLE_WIDTH;

    asac_pkg::cfg_t   cfg_reg;
    asac_pkg::res_t   result;
    logic             push_valid, push_ready;
    logic [SUM_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [SUM_W-1:0] pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_threshold_mg <= asac_pkg::MAG_W'(200);
            cfg_reg.lockout_samples   <= asac_pkg::LOCK_W'(5);
            cfg_reg.inactive_limit_mg <= asac_pkg::MAG_W'(30);
            cfg_reg.slow_limit_mg     <= asac_pkg::MAG_W'(150);
            cfg_reg.normal_limit_mg   <= asac_pkg::MAG_W'(300);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                asac_pkg::REG_STEP_THRESHOLD: cfg_reg.step_threshold_mg <= cfg_data;
                asac_pkg::REG_LOCKOUT:        cfg_reg.lockout_samples   <= cfg_data[7:0];
                asac_pkg::REG_INACTIVE_LIMIT: cfg_reg.inactive_limit_mg <= cfg_data;
                asac_pkg::REG_SLOW_LIMIT:     cfg_reg.slow_limit_mg     <= cfg_data;
                asac_pkg::REG_NORMAL_LIMIT:   cfg_reg.normal_limit_mg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    asac_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    asac_fifo #(
        .WIDTH(SUM_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    asac_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {3'b000, result};

endmodule

FILE: src/asac_front.sv
// Front end: takes samples, forms axis magnitudes and squares, pushes the sum of squares.
module asac_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [asac_pkg::IN_W-1:0]   s_tdata,
    output logic                        push_valid,
    input  logic                        push_ready,
    output logic [2*SAMPLE_WIDTH-1:0]   push_data
);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUM_W = 2 * SW;
    localparam int AW    = asac_pkg::AXIS_W;

    logic [SW-1:0] raw_x, raw_y, raw_z;
    logic [SW-1:0] abs_x, abs_y, abs_z;
    logic          abs_valid_reg;
    logic [SW-1:0] ax_reg, ay_reg, az_reg;
    logic          sq_valid_reg;
    logic [SUM_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic          abs_ready, sq_ready;

    assign raw_x = s_tdata[SW-1:0];
    assign raw_y = s_tdata[AW+SW-1:AW];
    assign raw_z = s_tdata[2*AW+SW-1:2*AW];

    // most negative code maps to 2^(SW-1), which still fits unsigned
    assign abs_x = raw_x[SW-1] ? (~raw_x + SW'(1)) : raw_x;
    assign abs_y = raw_y[SW-1] ? (~raw_y + SW'(1)) : raw_y;
    assign abs_z = raw_z[SW-1] ? (~raw_z + SW'(1)) : raw_z;

    assign sq_ready  = !sq_valid_reg || push_ready;
    assign abs_ready = !abs_valid_reg || sq_ready;
    assign s_tready  = abs_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
        end else begin
            if (abs_ready) begin
                abs_valid_reg <= s_tvalid;
            end
            if (sq_ready) begin
                sq_valid_reg <= abs_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (abs_ready && s_tvalid) begin
            ax_reg <= abs_x;
            ay_reg <= abs_y;
            az_reg <= abs_z;
        end
        if (sq_ready && abs_valid_reg) begin
            sqx_reg <= SUM_W'(ax_reg) * SUM_W'(ax_reg);
            sqy_reg <= SUM_W'(ay_reg) * SUM_W'(ay_reg);
            sqz_reg <= SUM_W'(az_reg) * SUM_W'(az_reg);
        end
    end

    // sum of three squares stays below 2^SUM_W
    assign push_valid = sq_valid_reg;
    assign push_data  = sqx_reg + sqy_reg + sqz_reg;

endmodule

FILE: src/asac_fifo.sv
// Two-entry queue between the front end and the root/decision back end.
module asac_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/asac_back.sv
// Back end: bit-pair integer square root, step detection, activity class, output register.
module asac_back #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asac_pkg::cfg_t                cfg,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  logic [2*SAMPLE_WIDTH-1:0]     pop_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output asac_pkg::res_t                result
);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUM_W = 2 * SW;
    localparam int CNT_W = $clog2(SW);
    localparam int MAG_W = asac_pkg::MAG_W;
    localparam int LOCK_W = asac_pkg::LOCK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W:0]    res_reg, res_next;
    logic [SUM_W-1:0]  bit_reg, bit_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W:0]    trial;

    logic [MAG_W-1:0]  prev_mag_reg, prev_mag_next;
    logic [LOCK_W-1:0] lock_left_reg, lock_left_next;
    logic              out_valid_reg, out_valid_next;
    asac_pkg::res_t    out_reg, out_next;

    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  delta, dev;
    logic              step;
    logic [asac_pkg::CLASS_W-1:0] cls;
    logic              load_out;

    assign trial = res_reg + {1'b0, bit_reg};
    assign mag   = MAG_W'({res_reg[SW-1:0], 2'b00});

    assign delta = (mag > prev_mag_reg) ? (mag - prev_mag_reg) : (prev_mag_reg - mag);
    assign dev   = (mag > asac_pkg::ONE_G_MG) ? (mag - asac_pkg::ONE_G_MG)
                                               : (asac_pkg::ONE_G_MG - mag);

    always_comb begin
        if (dev < cfg.inactive_limit_mg) begin
            cls = asac_pkg::CLASS_INACTIVE;
        end else if (dev < cfg.slow_limit_mg) begin
            cls = asac_pkg::CLASS_SLOW;
        end else if (dev < cfg.normal_limit_mg) begin
            cls = asac_pkg::CLASS_NORMAL;
        end else begin
            cls = asac_pkg::CLASS_FAST;
        end
    end

    always_comb begin
        step           = 1'b0;
        prev_mag_next  = mag;
        lock_left_next = lock_left_reg;
        if (prev_mag_reg != '0) begin
            if (lock_left_reg != '0) begin
                lock_left_next = lock_left_reg - LOCK_W'(1);
            end else if (delta >= cfg.step_threshold_mg) begin
                lock_left_next = cfg.lockout_samples;
                step           = 1'b1;
            end
        end
    end

    assign pop_ready = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    rem_next   = pop_data;
                    res_next   = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 2);
                    cnt_next   = CNT_W'(SW - 1);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_next = rem_reg - trial[SUM_W-1:0];
                    res_next = (res_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_next.magnitude_mg   = mag;
            out_next.step_detected  = step;
            out_next.activity_class = cls;
            out_valid_next          = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_mag_reg  <= '0;
            lock_left_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load_out) begin
                prev_mag_reg  <= prev_mag_next;
                lock_left_reg <= lock_left_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule
